// ===== src/ddiff_pkg.sv =====
// Package for the date difference block: payload words, controller/datapath
// command and status structs, state encoding and calendar helper functions.
// No dependencies.
package ddiff_pkg;

  localparam int unsigned YearW  = 14;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned CountW = 22;
  localparam int unsigned AccW   = 24;  // signed running total
  localparam int unsigned DoyW   = 9;   // day of year, at most 397
  localparam int unsigned ResW   = 9;   // year modulo 400

  localparam logic [YearW-1:0]  YearsPerCycle400 = YearW'(400);
  localparam logic [ResW-1:0]   ResLast          = ResW'(399);
  localparam logic [CountW-1:0] CountMax         = {CountW{1'b1}};

  typedef struct packed {
    logic [YearW-1:0]  first_year;
    logic [MonthW-1:0] first_month;
    logic [DayW-1:0]   first_day;
    logic [YearW-1:0]  second_year;
    logic [MonthW-1:0] second_month;
    logic [DayW-1:0]   second_day;
  } in_word_t;

  typedef struct packed {
    logic [CountW-1:0] day_count;
    logic              order_error;
  } out_word_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_FIRST,
    S_YEARS,
    S_SECOND,
    S_FINISH
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic mod_step;
    logic first;
    logic year_step;
    logic second;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic earlier;     // incoming word has first date strictly earlier
    logic mod_done;    // residue below 400
    logic years_done;  // year counter has reached the second year
    logic out_free;    // output register can take a word this cycle
  } dp_status_t;

  // Leap test on a year already reduced modulo 400 (year 0 counts as leap).
  function automatic logic leap_of(input logic [ResW-1:0] r);
    leap_of = (r[1:0] == 2'b00) && (r != ResW'(100)) && (r != ResW'(200))
              && (r != ResW'(300));
  endfunction

  // Days of the months before month m, February taken as 28.
  function automatic logic [DoyW-1:0] days_before_month(input logic [MonthW-1:0] m);
    logic [DoyW-1:0] v;
    case (m)
      4'd0, 4'd1: v = DoyW'(0);
      4'd2:       v = DoyW'(31);
      4'd3:       v = DoyW'(59);
      4'd4:       v = DoyW'(90);
      4'd5:       v = DoyW'(120);
      4'd6:       v = DoyW'(151);
      4'd7:       v = DoyW'(181);
      4'd8:       v = DoyW'(212);
      4'd9:       v = DoyW'(243);
      4'd10:      v = DoyW'(273);
      4'd11:      v = DoyW'(304);
      4'd12:      v = DoyW'(334);
      default:    v = DoyW'(365);
    endcase
    days_before_month = v;
  endfunction

  function automatic logic [DoyW-1:0] day_of_year(input logic [MonthW-1:0] m,
                                                  input logic [DayW-1:0]   d,
                                                  input logic              leap);
    logic feb_extra;
    feb_extra   = leap && (m >= MonthW'(3));
    day_of_year = days_before_month(m) + DoyW'(d) + DoyW'(feb_extra);
  endfunction

endpackage

// ===== src/ddiff_ctrl.sv =====
// Controller for the date difference block: sequences load, year reduction,
// year stepping and result write. Depends on ddiff_pkg.
module ddiff_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  ddiff_pkg::dp_status_t  status_i,
  output ddiff_pkg::ctrl_cmd_t   cmd_o,
  output logic                   busy_o
);
  import ddiff_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = status_i.earlier ? S_MOD : S_FINISH;
        end
      end
      S_MOD: begin
        if (status_i.mod_done) begin
          state_d = S_FIRST;
        end
      end
      S_FIRST:  state_d = S_YEARS;
      S_YEARS: begin
        if (status_i.years_done) begin
          state_d = S_SECOND;
        end
      end
      S_SECOND: state_d = S_FINISH;
      S_FINISH: begin
        if (status_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    case (state_q)
      S_IDLE: begin
        busy_o     = 1'b0;
        cmd_o.load = in_valid_i;
      end
      S_MOD:    cmd_o.mod_step  = !status_i.mod_done;
      S_FIRST:  cmd_o.first     = 1'b1;
      S_YEARS:  cmd_o.year_step = !status_i.years_done;
      S_SECOND: cmd_o.second    = 1'b1;
      S_FINISH: cmd_o.finish    = status_i.out_free;
      default:  busy_o          = 1'b1;
    endcase
  end

endmodule

// ===== src/ddiff_datapath.sv =====
// Datapath for the date difference block: operand registers, modulo-400
// residue, running day total, config bit and output register.
// Depends on ddiff_pkg.
module ddiff_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ddiff_pkg::in_word_t   in_data_i,
  input  logic                  cfg_we_i,
  input  logic                  cfg_data_i,
  input  ddiff_pkg::ctrl_cmd_t  cmd_i,
  output ddiff_pkg::dp_status_t status_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output ddiff_pkg::out_word_t  out_data_o
);
  import ddiff_pkg::*;

  logic [YearW-1:0]  year_q, year2_q, res_q;
  logic [MonthW-1:0] m1_q, m2_q;
  logic [DayW-1:0]   d1_q, d2_q;
  logic [AccW-1:0]   acc_q;
  logic              err_q;
  logic              end_q;
  logic              out_valid_q;
  out_word_t         out_q;

  logic              earlier;
  logic              leap;
  logic [DoyW-1:0]   doy1, doy2;
  logic [AccW-1:0]   pos;
  logic [AccW-1:0]   total;
  out_word_t         result;

  always_comb begin
    if (in_data_i.first_year != in_data_i.second_year) begin
      earlier = in_data_i.first_year < in_data_i.second_year;
    end else if (in_data_i.first_month != in_data_i.second_month) begin
      earlier = in_data_i.first_month < in_data_i.second_month;
    end else begin
      earlier = in_data_i.first_day < in_data_i.second_day;
    end
  end

  // residue is only meaningful below 400, which holds from S_FIRST onward
  assign leap = leap_of(res_q[ResW-1:0]);
  assign doy1 = day_of_year(m1_q, d1_q, leap);
  assign doy2 = day_of_year(m2_q, d2_q, leap);

  // negative span from odd day fields clamps to zero before the end day
  assign pos   = acc_q[AccW-1] ? '0 : acc_q;
  assign total = pos + AccW'(end_q);

  always_comb begin
    result.order_error = err_q;
    if (err_q) begin
      result.day_count = '0;
    end else if (total > AccW'(CountMax)) begin
      result.day_count = CountMax;
    end else begin
      result.day_count = total[CountW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      year_q  <= in_data_i.first_year;
      res_q   <= in_data_i.first_year;
      year2_q <= in_data_i.second_year;
      m1_q    <= in_data_i.first_month;
      d1_q    <= in_data_i.first_day;
      m2_q    <= in_data_i.second_month;
      d2_q    <= in_data_i.second_day;
      err_q   <= !earlier;
      acc_q   <= '0;
    end
    if (cmd_i.mod_step) begin
      res_q <= res_q - YearsPerCycle400;
    end
    if (cmd_i.first) begin
      acc_q <= '0 - AccW'(doy1);
    end
    if (cmd_i.year_step) begin
      acc_q  <= acc_q + AccW'(365) + AccW'(leap);
      year_q <= year_q + YearW'(1);
      res_q  <= (res_q[ResW-1:0] == ResLast) ? '0 : res_q + YearW'(1);
    end
    if (cmd_i.second) begin
      acc_q <= acc_q + AccW'(doy2);
    end
    if (cmd_i.finish) begin
      out_q <= result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      end_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        end_q <= cfg_data_i;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.earlier    = earlier;
  assign status_o.mod_done   = res_q < YearsPerCycle400;
  assign status_o.years_done = year_q == year2_q;
  assign status_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== src/date_difference_in_days.sv =====
// Gregorian date difference: one word in carries two dates, one word out
// carries the day count from the first to the second and an order-error
// flag (count zero) when the first date is not strictly earlier. Setting
// the include-end-day bit adds one to the count; the count saturates at
// the top of its 22-bit field. Words are taken one at a time: a date pair
// in order passes through a reduction of the first year modulo 400 (400
// per cycle), a first-date step, a year loop that adds one year length
// per cycle up to the second year, a second-date step and a finish step;
// a pair out of order goes straight to the finish step. The finish step
// waits while the output stays stalled with a word already waiting. A
// finished word waits in the output register while the next word is
// taken. Depends on ddiff_pkg, ddiff_ctrl, ddiff_datapath.
module date_difference_in_days (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  ddiff_pkg::in_word_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output ddiff_pkg::out_word_t out_data_o,
  input  logic                 cfg_we_i,
  input  logic                 cfg_data_i
);
  import ddiff_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       busy;

  ddiff_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .busy_o     (busy)
  );

  ddiff_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  assign in_stall_o = busy;

`ifndef SYNTHESIS
  // an order error never carries a count
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.order_error |-> out_data_o.day_count == '0)
    else $error("order error with non-zero day count");

  // an accepted word keeps the input stalled for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accepting a word");

  // a finishing command comes only while busy and only into a free output slot
  a_finish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> status.out_free && busy)
    else $error("result written into an occupied output register");
`endif

endmodule
